[rtl/hsf_pkg.sv]
// ----------------------------------------------------------------------------
// hsf_pkg
// Shared widths and constants for the cubic Hermite segment fitter.
// ----------------------------------------------------------------------------
package hsf_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int COEF_FRAC_BITS = 32;

   localparam int TIME_W  = 32;
   localparam int MIN_W   = 16;
   localparam int MUL_A_W = 35;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;
   localparam int NUM_W   = 116;
   localparam int DEN_W   = 96;
   localparam int COEF_W  = 64;
   localparam int CNT_W   = 7;

   localparam int SH_C2_POS = FRAC_BITS + COEF_FRAC_BITS;
   localparam int SH_C2_VEL = COEF_FRAC_BITS;
   localparam int SH_C3_POS = 2 * FRAC_BITS + COEF_FRAC_BITS + 1;
   localparam int SH_C3_VEL = FRAC_BITS + COEF_FRAC_BITS;

   localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(NUM_W - 1);
   localparam logic [COEF_W-1:0] SAT_POS  = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic [COEF_W-1:0] SAT_NEG  = {1'b1, {(COEF_W-1){1'b0}}};

endpackage

[rtl/hsf_mul.sv]
// ----------------------------------------------------------------------------
// hsf_mul
// Shared signed-by-unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module hsf_mul
   import hsf_pkg::*;
(
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] mul_a,
   input  logic        [MUL_B_W-1:0] mul_b,
   output logic signed [PROD_W-1:0]  prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a * $signed({1'b0, mul_b}));
   end

endmodule

[rtl/hsf_div.sv]
// ----------------------------------------------------------------------------
// hsf_div
// Restoring divider, one quotient bit per cycle, with signed saturation.
// ----------------------------------------------------------------------------
module hsf_div
   import hsf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   input  logic        [DEN_W-1:0] den,
   output logic                    done_ff,
   output logic        [COEF_W-1:0] quo,
   output logic                    sat
);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] den_ff;
   logic             neg_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;
   logic             high;
   logic [COEF_W-1:0] mag;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         neg_ff <= num[NUM_W-1];
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
      end
   end

   assign high = |quo_ff[NUM_W-1:COEF_W];
   assign mag  = quo_ff[COEF_W-1:0];

   always_comb begin
      if (neg_ff) begin
         sat = high || (mag > SAT_NEG);
         quo = sat ? SAT_NEG : COEF_W'(-mag);
      end else begin
         sat = high || mag[COEF_W-1];
         quo = sat ? SAT_POS : mag;
      end
   end

endmodule

[rtl/cubic_hermite_segment_fit_core.sv]
// ----------------------------------------------------------------------------
// cubic_hermite_segment_fit_core
// Fits one cubic Hermite segment between consecutive knot points.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one knot point per transaction: tdata holds time, position
//   and velocity, tuser the start-new-curve flag. rsp_ carries one segment:
//   begin and end time, c0, c1, c2 and c3, with tuser flagging a clipped
//   coefficient. csr_ writes min_interval; write it only while idle.
//   A point that forms no segment is taken and req_tready stays high. A point
//   that forms a segment holds req_tready low through the steps of the fit:
//   the shared multiplier, then for c2 (by T^2) and for c3 (by T^3) a
//   numerator step, a load step and a run of the bit-serial divider (116
//   quotient bits), and last the load of the output register.
//   The segment waits in the output register; a stalled receiver holds the
//   block before it loads the next segment, never drops one.
//   Reset clears the stored point, the output valid and sets min_interval
//   to one.
// ----------------------------------------------------------------------------
module cubic_hermite_segment_fit_core
   import hsf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // point_time, point_position, point_velocity
   input  logic         req_tuser,   // start_new
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [255:0] rsp_tdata,   // seg_begin, seg_finish, coef_constant,
                                     // coef_linear, coef_quadratic, coef_cubic
   output logic         rsp_tuser,   // saturated
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data     // min_interval
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_NUM  = 3'd2;
   localparam logic [2:0] S_LOAD = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  step_ff;
   logic        phase_ff;
   logic [MIN_W-1:0]  min_ff;
   logic        have_prev_ff;
   logic [TIME_W-1:0] prev_time_ff, prev_pos_ff, prev_vel_ff;
   logic [TIME_W-1:0] seg_begin_ff, seg_finish_ff, seg_pos_ff, seg_vel_ff;
   logic [TIME_W-1:0] t_ff;
   logic signed [32:0] dp_ff, s3_ff;
   logic signed [33:0] s2_ff;
   logic signed [PROD_W-1:0] pa2_ff, pa3_ff;
   logic [COEF_W-1:0] t2sq_ff, t3lo_ff, t3hi_ff;
   logic signed [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [COEF_W-1:0] c2_ff;
   logic [COEF_W-1:0] c3_ff;
   logic        sat_ff;
   logic        rsp_valid_ff;
   logic [255:0] rsp_data_ff;
   logic        rsp_user_ff;

   logic [TIME_W-1:0] t2, p2, v2;
   logic        acc, seg_go, out_free;
   logic [TIME_W-1:0] dt;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [PROD_W-1:0]  prod;
   logic signed [NUM_W-1:0]   dpx, pa2x, pa3x, n2, n3;
   logic [DEN_W-1:0]  t3;
   logic        div_done, div_sat;
   logic [COEF_W-1:0] div_quo;

   assign t2  = req_tdata[31:0];
   assign p2  = req_tdata[63:32];
   assign v2  = req_tdata[95:64];
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign acc = req_tvalid && req_tready;
   assign dt  = t2 - prev_time_ff;
   assign seg_go = have_prev_ff && !req_tuser && (t2 > prev_time_ff)
                   && (dt > TIME_W'(min_ff));
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      case (step_ff)
         3'd0:    mul_a = MUL_A_W'(s2_ff);
         3'd1:    mul_a = MUL_A_W'(s3_ff);
         3'd2:    mul_a = $signed({3'b000, t_ff});
         3'd4:    mul_a = $signed({3'b000, t2sq_ff[31:0]});
         3'd5:    mul_a = $signed({3'b000, t2sq_ff[63:32]});
         default: mul_a = '0;
      endcase
   end

   hsf_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (t_ff),
      .prod_ff (prod)
   );

   assign dpx  = NUM_W'(dp_ff);
   assign pa2x = NUM_W'(pa2_ff);
   assign pa3x = NUM_W'(pa3_ff);
   assign n2   = (((dpx <<< 1) + dpx) <<< SH_C2_POS) - (pa2x <<< SH_C2_VEL);
   assign n3   = (pa3x <<< SH_C3_VEL) - (dpx <<< SH_C3_POS);
   assign t3   = {t3hi_ff, 32'd0} + {32'd0, t3lo_ff};

   hsf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == S_LOAD),
      .num     (num_ff),
      .den     (den_ff),
      .done_ff (div_done),
      .quo     (div_quo),
      .sat     (div_sat)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (acc && seg_go) state_in = S_MUL;
         S_MUL:   if (step_ff == 3'd6) state_in = S_NUM;
         S_NUM:   state_in = S_LOAD;
         S_LOAD:  state_in = S_DIV;
         S_DIV:   if (div_done) state_in = phase_ff ? S_OUT : S_NUM;
         S_OUT:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         phase_ff     <= 1'b0;
         min_ff       <= MIN_W'(1);
         have_prev_ff <= 1'b0;
         prev_time_ff <= '0;
         prev_pos_ff  <= '0;
         prev_vel_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            min_ff <= csr_data;
         end
         if (acc) begin
            have_prev_ff <= 1'b1;
            prev_time_ff <= t2;
            prev_pos_ff  <= p2;
            prev_vel_ff  <= v2;
            step_ff      <= '0;
            phase_ff     <= 1'b0;
         end else if (state_ff == S_MUL) begin
            step_ff <= step_ff + 1'b1;
         end
         if (state_ff == S_DIV && div_done) begin
            phase_ff <= 1'b1;
         end
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         seg_begin_ff  <= prev_time_ff;
         seg_finish_ff <= t2;
         seg_pos_ff    <= prev_pos_ff;
         seg_vel_ff    <= prev_vel_ff;
         t_ff          <= dt;
         dp_ff  <= $signed({p2[31], p2}) - $signed({prev_pos_ff[31], prev_pos_ff});
         s2_ff  <= $signed({prev_vel_ff[31], prev_vel_ff, 1'b0})
                   + $signed({{2{v2[31]}}, v2});
         s3_ff  <= $signed({prev_vel_ff[31], prev_vel_ff}) + $signed({v2[31], v2});
         sat_ff <= 1'b0;
      end
      if (state_ff == S_MUL) begin
         case (step_ff)
            3'd1:    pa2_ff  <= prod;
            3'd2:    pa3_ff  <= prod;
            3'd3:    t2sq_ff <= prod[COEF_W-1:0];
            3'd5:    t3lo_ff <= prod[COEF_W-1:0];
            3'd6:    t3hi_ff <= prod[COEF_W-1:0];
            default: ;
         endcase
      end
      if (state_ff == S_NUM) begin
         num_ff <= phase_ff ? n3 : n2;
         den_ff <= phase_ff ? t3 : {32'd0, t2sq_ff};
      end
      if (state_ff == S_DIV && div_done) begin
         sat_ff <= sat_ff | div_sat;
         if (!phase_ff) begin
            c2_ff <= div_quo;
         end else begin
            c3_ff <= div_quo;
         end
      end
      if (state_ff == S_OUT && out_free) begin
         rsp_data_ff <= {c3_ff, c2_ff, seg_vel_ff, seg_pos_ff,
                         seg_finish_ff, seg_begin_ff};
         rsp_user_ff <= sat_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[rtl/hsf_checker.sv]
// ----------------------------------------------------------------------------
// hsf_checker
// Port-level checks for the cubic Hermite segment fitter.
// ----------------------------------------------------------------------------
module hsf_checker
   import hsf_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [255:0] rsp_tdata,
   input logic         rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_start_free: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> req_tready)
      else $error("start point made the block busy");

   a_start_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !$rose(rsp_tvalid))
      else $error("segment from a start point");

   a_time_order: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> rsp_tdata[63:32] > rsp_tdata[31:0])
      else $error("segment end not after begin");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[191:128] == SAT_POS || rsp_tdata[191:128] == SAT_NEG ||
         rsp_tdata[255:192] == SAT_POS || rsp_tdata[255:192] == SAT_NEG)
      else $error("saturated flag without a clipped coefficient");

endmodule

bind cubic_hermite_segment_fit_core hsf_checker u_hsf_checker (.*);

[tb/sv/hsf_segment_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsf_segment_checker
// Watches the knot, segment and register channels of the Hermite segment
// fitter, predicts each segment from its own copy of the stored knot and
// min_interval, and compares every segment transaction field by field.
// ----------------------------------------------------------------------------
module hsf_segment_checker
   import hsf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [95:0]  req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [255:0] rsp_tdata,
   input  logic         rsp_tuser,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [15:0]  csr_data,
   output int           mismatches,
   output int           pending
);

   typedef struct packed {
      logic [31:0] seg_begin;
      logic [31:0] seg_finish;
      logic [31:0] coef_constant;
      logic [31:0] coef_linear;
      logic [63:0] coef_quadratic;
      logic [63:0] coef_cubic;
      logic        saturated;
   } segment_type;

   segment_type     segments_due[$];
   logic [31:0]     knot_time, knot_pos, knot_vel;
   logic            knot_valid;
   logic [MIN_W-1:0] min_gap;

   assign pending = segments_due.size();

   function automatic logic [63:0] clip_quotient(input logic signed [199:0] num,
                                                 input logic [199:0] den,
                                                 inout logic clipped);
      logic        neg;
      logic [199:0] mag, q;
      neg = num < 0;
      mag = neg ? -num : num;
      q   = mag / den;
      if (neg) begin
         if (q > {136'd0, SAT_NEG}) begin
            clipped = 1'b1;
            return SAT_NEG;
         end
         return -q[63:0];
      end
      if (q > {136'd0, SAT_POS}) begin
         clipped = 1'b1;
         return SAT_POS;
      end
      return q[63:0];
   endfunction

   function automatic segment_type fit_segment(input logic [31:0] t2,
                                               input logic [31:0] p2,
                                               input logic [31:0] v2);
      segment_type           s;
      logic signed [199:0]   p1w, v1w, p2w, v2w, dp, tw, n2, n3;
      logic [199:0]          d2, d3;
      logic                  clipped;
      clipped = 1'b0;
      p1w = $signed(knot_pos);
      v1w = $signed(knot_vel);
      p2w = $signed(p2);
      v2w = $signed(v2);
      tw  = {168'd0, t2 - knot_time};
      dp  = p2w - p1w;
      d2  = tw * tw;
      d3  = d2 * tw;
      n2  = ((3 * dp) <<< (FRAC_BITS + COEF_FRAC_BITS))
            - (((2 * v1w + v2w) * tw) <<< COEF_FRAC_BITS);
      n3  = ((-2 * dp) <<< (2 * FRAC_BITS + COEF_FRAC_BITS))
            + (((v1w + v2w) * tw) <<< (FRAC_BITS + COEF_FRAC_BITS));
      s.seg_begin      = knot_time;
      s.seg_finish     = t2;
      s.coef_constant  = knot_pos;
      s.coef_linear    = knot_vel;
      s.coef_quadratic = clip_quotient(n2, d2, clipped);
      s.coef_cubic     = clip_quotient(n3, d3, clipped);
      s.saturated      = clipped;
      return s;
   endfunction

   always @(posedge clock) begin
      segment_type want, got;
      if (reset) begin
         knot_time  <= '0;
         knot_pos   <= '0;
         knot_vel   <= '0;
         knot_valid <= 1'b0;
         min_gap    <= MIN_W'(1);
         segments_due.delete();
         mismatches <= 0;
      end else begin
         if (csr_valid && csr_ready)
            min_gap <= csr_data;
         if (req_tvalid && req_tready) begin
            if (knot_valid && !req_tuser && req_tdata[31:0] > knot_time &&
                (req_tdata[31:0] - knot_time) > {16'd0, min_gap})
               segments_due.insert(segments_due.size(),
                                   fit_segment(req_tdata[31:0],
                                               req_tdata[63:32],
                                               req_tdata[95:64]));
            knot_time  <= req_tdata[31:0];
            knot_pos   <= req_tdata[63:32];
            knot_vel   <= req_tdata[95:64];
            knot_valid <= 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                   rsp_tdata[127:96], rsp_tdata[191:128], rsp_tdata[255:192],
                   rsp_tuser};
            if (segments_due.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected segment %h", got);
               mismatches <= mismatches + 1;
            end else begin
               want = segments_due.pop_front();
               if (got !== want) begin
                  if (mismatches < 10) begin
                     $display("segment mismatch at %0t", $realtime);
                     $display("  begin  exp %h got %h", want.seg_begin, got.seg_begin);
                     $display("  finish exp %h got %h", want.seg_finish, got.seg_finish);
                     $display("  c0     exp %h got %h", want.coef_constant,
                              got.coef_constant);
                     $display("  c1     exp %h got %h", want.coef_linear,
                              got.coef_linear);
                     $display("  c2     exp %h got %h", want.coef_quadratic,
                              got.coef_quadratic);
                     $display("  c3     exp %h got %h", want.coef_cubic,
                              got.coef_cubic);
                     $display("  sat    exp %b got %b", want.saturated, got.saturated);
                  end
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

[tb/sv/tb_cubic_hermite_segment_fit_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cubic_hermite_segment_fit_core
// Drives knot points and min_interval settings into the segment fitter with
// random idling on both channels; the checker predicts and compares segments.
// ----------------------------------------------------------------------------
module tb_cubic_hermite_segment_fit_core;
   import hsf_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid, req_tready, req_tuser;
   logic [95:0]  req_tdata;
   logic         rsp_tvalid, rsp_tready, rsp_tuser;
   logic [255:0] rsp_tdata;
   logic         csr_valid, csr_ready;
   logic [15:0]  csr_data;
   int           mismatches, pending;
   logic         quiet;
   logic [31:0]  last_time;
   logic [15:0]  gap_now;

   cubic_hermite_segment_fit_core dut (.*);
   hsf_segment_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #12ms;
      $display("tb: failure");
      $finish;
   end

   // receiver stalls
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_knot(input logic [31:0] t, input logic [31:0] p,
                            input logic [31:0] v, input logic s);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {v, p, t};
      req_tuser  <= s;
      do @(posedge clock); while (!req_tready);
      last_time = t;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_gap(input logic [15:0] g);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= g;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      gap_now = g;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
      endcase
   endfunction

   task automatic random_knot();
      logic [31:0] t;
      int          r;
      r = $urandom_range(0, 99);
      if (r < 4)
         send_knot($urandom(), pick_value(), pick_value(), 1'b1);
      else begin
         if (r < 8)
            t = ($urandom_range(0, 1)) ? $urandom() : last_time - $urandom_range(1, 300);
         else if (r < 13)
            t = last_time + $urandom_range(0, gap_now);
         else if (r < 50)
            t = last_time + gap_now + $urandom_range(1, 64);
         else if (r < 80)
            t = last_time + gap_now + $urandom_range(1, 65535);
         else if (r < 95)
            t = last_time + gap_now + $urandom_range(1, 16777215);
         else
            t = last_time + $urandom();
         send_knot(t, pick_value(), pick_value(), 1'b0);
      end
   endtask

   initial begin
      reset      = 1'b1;
      quiet      = 1'b0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      gap_now    = 16'd1;
      last_time  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed knots
      send_knot(32'd5, 32'd0, 32'd0, 1'b0);
      send_knot(32'd6, 32'd7, 32'd1, 1'b0);
      send_knot(32'd8, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_knot(32'd10, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      send_knot(32'd9, 32'h0001_0000, 32'd0, 1'b0);
      send_knot(32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000, 1'b0);
      send_knot(32'h0004_0000, 32'h0003_0000, 32'h0000_8000, 1'b1);
      send_knot(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_knot(32'd0, 32'h1234_5678, 32'h8765_4321, 1'b1);
      send_knot(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
      send_knot(32'h0000_0001, 32'h0, 32'h0, 1'b1);
      send_knot(32'h0000_0003, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      write_gap(16'd0);
      send_knot(32'd3, 32'd1, 32'd1, 1'b0);
      send_knot(32'd4, 32'd2, 32'd2, 1'b0);
      write_gap(16'hFFFF);
      send_knot(32'h0001_0003, 32'd5, 32'd5, 1'b0);
      send_knot(32'h0002_0003, 32'd9, 32'hFFFF_FFF0, 1'b0);

      // random phases at several settings
      repeat (90) random_knot();
      write_gap(16'd0);
      repeat (90) random_knot();
      drain();
      write_gap(16'($urandom()));
      repeat (90) random_knot();
      write_gap(16'd1);
      repeat (70) random_knot();
      quiet = 1'b1;
      repeat (60) random_knot();
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[files.f]
rtl/hsf_pkg.sv
rtl/hsf_mul.sv
rtl/hsf_div.sv
rtl/cubic_hermite_segment_fit_core.sv
rtl/hsf_checker.sv
tb/sv/hsf_segment_checker.sv
tb/sv/tb_cubic_hermite_segment_fit_core.sv
